FILE: sv/range_tagged_block_directory_defines.svh
// Assertion macros for the range-tagged block directory.
// Depends on nothing; included by the top level only.
`ifndef RANGE_TAGGED_BLOCK_DIRECTORY_DEFINES_SVH
`define RANGE_TAGGED_BLOCK_DIRECTORY_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RTBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtbd assertion failed");

// next-cycle implication, disabled in reset
`define RTBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtbd assertion failed");

`endif

FILE: sv/rtbd_pkg.sv
// Shared types and codes for the range-tagged block directory.
// Depends on nothing; used by every module of the block.
package rtbd_pkg;

  localparam int DEFAULT_ENTRIES = 16;

  localparam int ACT_W    = 3;
  localparam int FID_W    = 64;
  localparam int OFF_W    = 48;
  localparam int LEN_W    = 32;
  localparam int SEL_W    = 4;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int REM_W    = 5;
  localparam int TOTAL_W  = 36;
  localparam int END_W    = OFF_W + 1;
  localparam int REM_MAX  = 31;

  localparam logic [ACT_W-1:0] ACT_RESERVE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIND      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLR_FID   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLR_OFF   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLR_ALL   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [FID_W-1:0] file_id;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] length;
    logic [SEL_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  found_slot;
    logic [REM_W-1:0]   removed_count;
    logic [TOTAL_W-1:0] total_bytes;
  } rsp_t;

  typedef struct packed {
    logic [FID_W-1:0] file_id;
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic finish;
  } ctrl_cmd_t;

endpackage

FILE: sv/rtbd_ctrl.sv
// Scan sequencer for the range-tagged block directory.
// Depends on rtbd_pkg; drives the datapath through ctrl_cmd_t and a read address.
module rtbd_ctrl #(
  parameter int ENTRIES = rtbd_pkg::DEFAULT_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output rtbd_pkg::ctrl_cmd_t   cmd,
  output logic [IDX_W-1:0]      rd_addr
);
  import rtbd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        idx_next  = idx + 1'b1;
        if (idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign busy    = (state != S_IDLE);
  assign rd_addr = idx;

endmodule

FILE: sv/rtbd_datapath.sv
// Entry memory, valid bits, match logic and result register of the directory.
// Depends on rtbd_pkg; sequenced by rtbd_ctrl.
module rtbd_datapath #(
  parameter int ENTRIES = rtbd_pkg::DEFAULT_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rtbd_pkg::ctrl_cmd_t  cmd,
  input  logic [IDX_W-1:0]     rd_addr,
  input  rtbd_pkg::req_t       req,
  output logic                 done,
  output rtbd_pkg::rsp_t       rsp
);
  import rtbd_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;

  entry_t             mem [ENTRIES];
  entry_t             rd_data;
  req_t               req_r;
  logic [END_W-1:0]   req_end;
  logic               eval_en;
  logic [IDX_W-1:0]   eval_idx;
  logic [ENTRIES-1:0] valid, valid_next;
  logic               found, found_next;
  logic [IDX_W-1:0]   found_idx, found_idx_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [TOTAL_W-1:0] total, total_next;

  logic             cur_valid;
  logic             fid_hit;
  logic             start_le;
  logic             end_ge;
  logic             reserve_hit;
  logic             find_hit;
  logic             drop;
  logic [STAT_W-1:0] status_next;

  assign cur_valid = valid[eval_idx];
  assign fid_hit   = (rd_data.file_id == req_r.file_id);
  assign start_le  = (rd_data.start <= req_r.start_offset);
  assign end_ge    = ((END_W'(rd_data.start) + END_W'(rd_data.length)) >= req_end);

  always_comb begin
    reserve_hit = 1'b0;
    find_hit    = 1'b0;
    drop        = 1'b0;
    case (req_r.action)
      ACT_RESERVE: reserve_hit = eval_en && !cur_valid && !found;
      ACT_FIND:    find_hit = eval_en && cur_valid && !found && fid_hit && start_le && end_ge;
      ACT_CLR_FID: drop = eval_en && cur_valid && fid_hit;
      ACT_CLR_OFF: drop = eval_en && cur_valid && fid_hit && start_le;
      ACT_DELETE:  drop = eval_en && cur_valid &&
                          (CMP_W'(eval_idx) == CMP_W'(req_r.slot_index));
      ACT_CLR_ALL: drop = eval_en && cur_valid;
      default:     drop = 1'b0;
    endcase
  end

  always_comb begin
    valid_next     = valid;
    found_next     = found;
    found_idx_next = found_idx;
    cnt_next       = cnt;
    total_next     = total;
    if (reserve_hit) begin
      valid_next[eval_idx] = 1'b1;
      total_next           = total + TOTAL_W'(req_r.length);
    end
    if (reserve_hit || find_hit) begin
      found_next     = 1'b1;
      found_idx_next = eval_idx;
    end
    if (drop) begin
      valid_next[eval_idx] = 1'b0;
      total_next           = total - TOTAL_W'(rd_data.length);
      cnt_next             = cnt + 1'b1;
    end
  end

  always_comb begin
    case (req_r.action)
      ACT_RESERVE: status_next = found_next ? ST_OK : ST_FULL;
      ACT_FIND:    status_next = found_next ? ST_OK : ST_MISS;
      ACT_CLR_FID,
      ACT_CLR_OFF,
      ACT_CLR_ALL: status_next = ST_OK;
      ACT_DELETE:  status_next = (cnt_next != '0) ? ST_OK : ST_MISS;
      default:     status_next = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (reserve_hit) begin
      mem[eval_idx] <= '{file_id: req_r.file_id, start: req_r.start_offset,
                         length: req_r.length};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= rd_addr;
    if (cmd.load) begin
      req_r   <= req;
      req_end <= END_W'(req.start_offset) + END_W'(req.length);
    end
    if (cmd.finish) begin
      rsp.status        <= status_next;
      rsp.found_slot    <= found_next ? SLOT_W'(found_idx_next) : '0;
      rsp.removed_count <= (32'(cnt_next) > 32'(REM_MAX)) ? REM_W'(REM_MAX)
                                                           : REM_W'(cnt_next);
      rsp.total_bytes   <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_en   <= 1'b0;
      valid     <= '0;
      found     <= 1'b0;
      found_idx <= '0;
      cnt       <= '0;
      total     <= '0;
      done      <= 1'b0;
    end else begin
      eval_en <= cmd.rd_en;
      done    <= cmd.finish;
      valid   <= valid_next;
      total   <= total_next;
      if (cmd.load) begin
        found     <= 1'b0;
        found_idx <= '0;
        cnt       <= '0;
      end else begin
        found     <= found_next;
        found_idx <= found_idx_next;
        cnt       <= cnt_next;
      end
    end
  end

endmodule

FILE: sv/range_tagged_block_directory.sv
// Top level of the range-tagged block directory: sequencer plus datapath.
// Depends on rtbd_pkg, rtbd_ctrl, rtbd_datapath and the defines header.
//
// Usage:
//   Request channel: drive req and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. busy stays high
//   until the result has been produced.
//   Result channel: done pulses for exactly one cycle with rsp holding
//   status, found_slot, removed_count and total_bytes.
// Timing:
//   Every action walks all ENTRIES slots of the entry memory, one read per
//   cycle, then evaluates the last slot in the drain state. done rises in
//   the same cycle that busy falls, so a new request can be taken while done
//   is high; no new request is taken while a scan is still running.
// Reset:
//   rst clears all valid bits, the byte total and the sequencer; the entry
//   memory is not cleared and needs no clearing pass.
// Receiver:
//   The receiver cannot stall; rsp is valid only while done is high.
module range_tagged_block_directory #(
  parameter int ENTRIES = rtbd_pkg::DEFAULT_ENTRIES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  rtbd_pkg::req_t  req,
  output logic            done,
  output rtbd_pkg::rsp_t  rsp
);
  import rtbd_pkg::*;

  `include "range_tagged_block_directory_defines.svh"

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ctrl_cmd_t        cmd;
  logic [IDX_W-1:0] rd_addr;

  rtbd_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  rtbd_datapath #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .req     (req),
    .done    (done),
    .rsp     (rsp)
  );

  `RTBD_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `RTBD_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `RTBD_ASSERT_NEXT(a_finish_done, clk, rst, cmd.finish, done)
  `RTBD_ASSERT_NEXT(a_load_scan, clk, rst, cmd.load, cmd.rd_en && !done)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for range_tagged_block_directory.
// Depends on rtbd_pkg and the RTL; it mirrors the slot table, predicts every
// result, and drives directed actions followed by random action traffic.
module tb_top;
  import rtbd_pkg::*;

  localparam int ENTRIES = DEFAULT_ENTRIES;
  localparam int STALL_LIMIT = 400;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [FID_W-1:0] FID_ONES = '1;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  logic               dir_valid [ENTRIES];
  logic [FID_W-1:0]   dir_fid   [ENTRIES];
  logic [OFF_W-1:0]   dir_start [ENTRIES];
  logic [LEN_W-1:0]   dir_len   [ENTRIES];
  logic [TOTAL_W-1:0] dir_total;

  logic [FID_W-1:0] fid_pool [6];
  rsp_t awaited_rsp [$];
  rsp_t next_expected;
  bit   idle_on;
  int   error_count;
  int   idle_cycles;
  int   actions_sent;
  int   find_hits;
  int   full_rejects;
  int   entries_removed;

  range_tagged_block_directory DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #2 clk = ~clk;

  function automatic rsp_t predict_directory(input req_t r);
    rsp_t res;
    logic [OFF_W:0] have_end;
    logic [OFF_W:0] want_end;
    res = '0;
    res.status = ST_OK;
    case (r.action)
      ACT_RESERVE: begin
        res.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!dir_valid[i]) begin
            dir_valid[i] = 1'b1;
            dir_fid[i] = r.file_id;
            dir_start[i] = r.start_offset;
            dir_len[i] = r.length;
            dir_total = dir_total + TOTAL_W'(r.length);
            res.status = ST_OK;
            res.found_slot = SLOT_W'(i);
            break;
          end
        end
      end
      ACT_FIND: begin
        res.status = ST_MISS;
        want_end = {1'b0, r.start_offset} + (OFF_W+1)'(r.length);
        for (int i = 0; i < ENTRIES; i++) begin
          have_end = {1'b0, dir_start[i]} + (OFF_W+1)'(dir_len[i]);
          if (dir_valid[i] && dir_fid[i] == r.file_id && dir_start[i] <= r.start_offset &&
              have_end >= want_end) begin
            res.status = ST_OK;
            res.found_slot = SLOT_W'(i);
            break;
          end
        end
      end
      ACT_CLR_FID, ACT_CLR_OFF, ACT_CLR_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_valid[i] && (r.action == ACT_CLR_ALL || (dir_fid[i] == r.file_id &&
              (r.action == ACT_CLR_FID || dir_start[i] <= r.start_offset)))) begin
            dir_valid[i] = 1'b0;
            dir_total = dir_total - TOTAL_W'(dir_len[i]);
            res.removed_count = res.removed_count + 1'b1;
          end
        end
      end
      ACT_DELETE: begin
        if (dir_valid[r.slot_index]) begin
          dir_valid[r.slot_index] = 1'b0;
          dir_total = dir_total - TOTAL_W'(dir_len[r.slot_index]);
          res.removed_count = REM_W'(1);
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        res.status = ST_MISS;
      end
    endcase
    res.total_bytes = dir_total;
    return res;
  endfunction

  function automatic req_t make_req(input logic [ACT_W-1:0] act, input logic [FID_W-1:0] fid,
                                    input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                                    input logic [SEL_W-1:0] sel);
    req_t r;
    r.action = act;
    r.file_id = fid;
    r.start_offset = off;
    r.length = len;
    r.slot_index = sel;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    case ($urandom_range(0, 9))
      0: return OFF_W'($urandom_range(0, 255));
      1: return OFF_MAX - OFF_W'($urandom_range(0, 255));
      default: return OFF_W'(rand64());
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LEN_MAX;
      2, 3, 4: return LEN_W'($urandom_range(1, 4096));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  function automatic logic [FID_W-1:0] pick_fid();
    if ($urandom_range(0, 9) < 7) return fid_pool[$urandom_range(0, 5)];
    return rand64();
  endfunction

  function automatic int pick_valid_slot();
    int live [$];
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_valid[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic req_t random_action(input int reserve_pct);
    req_t r;
    int k;
    int roll;
    logic [OFF_W:0] span_end;
    logic [OFF_W:0] off_wide;
    logic [OFF_W:0] room;
    r = make_req(ACT_RESERVE, pick_fid(), rand_offset(), rand_length(), SEL_W'($urandom));
    k = pick_valid_slot();
    roll = $urandom_range(0, 99);
    if (roll >= reserve_pct) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        r.action = ACT_FIND;
        if (k >= 0 && $urandom_range(0, 9) < 7) begin
          r.file_id = dir_fid[k];
          span_end = {1'b0, dir_start[k]} + (OFF_W+1)'(dir_len[k]);
          case ($urandom_range(0, 3))
            0: begin
              r.start_offset = dir_start[k];
              r.length = dir_len[k];
            end
            1: begin
              r.start_offset = dir_start[k];
              r.length = dir_len[k] + 1'b1;
            end
            2: begin
              r.start_offset = dir_start[k] - 1'b1;
              r.length = LEN_W'($urandom_range(0, 3));
            end
            default: begin
              off_wide = {1'b0, dir_start[k]} +
                         (OFF_W+1)'(rand64() % (64'(dir_len[k]) + 64'd1));
              if (off_wide[OFF_W]) off_wide = {1'b0, dir_start[k]};
              room = span_end - off_wide;
              r.start_offset = off_wide[OFF_W-1:0];
              r.length = LEN_W'(rand64() % (64'(room) + 64'd1));
            end
          endcase
        end
      end else if (roll < 60) begin
        r.action = ACT_DELETE;
        if (k >= 0 && $urandom_range(0, 1) == 0) r.slot_index = SEL_W'(k);
      end else if (roll < 72) begin
        r.action = ACT_CLR_FID;
        if (k >= 0 && $urandom_range(0, 9) < 7) r.file_id = dir_fid[k];
      end else if (roll < 86) begin
        r.action = ACT_CLR_OFF;
        if (k >= 0 && $urandom_range(0, 9) < 7) begin
          r.file_id = dir_fid[k];
          case ($urandom_range(0, 3))
            0: r.start_offset = dir_start[k] - 1'b1;
            1: r.start_offset = dir_start[k];
            2: r.start_offset = dir_start[k] + 1'b1;
            default: r.start_offset = rand_offset();
          endcase
        end
      end else if (roll < 92) begin
        r.action = ACT_CLR_ALL;
      end else begin
        r.action = ($urandom_range(0, 1) == 0) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
      end
    end
    return r;
  endfunction

  task automatic send_action(input req_t r);
    rsp_t exp_rsp;
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    exp_rsp = predict_directory(r);
    awaited_rsp.push_back(exp_rsp);
    actions_sent++;
    if (r.action == ACT_FIND && exp_rsp.status == ST_OK) find_hits++;
    if (exp_rsp.status == ST_FULL) full_rejects++;
    entries_removed += exp_rsp.removed_count;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, ENTRIES + 1)) @(posedge clk);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic test_fill_to_full();
    send_action(make_req(ACT_RESERVE, FID_ONES, OFF_MAX, LEN_MAX, '1));
    send_action(make_req(ACT_RESERVE, '0, '0, '0, '0));
    send_action(make_req(ACT_RESERVE, '0, OFF_W'(100), LEN_W'(50), '0));
    for (int i = 3; i < ENTRIES; i++) begin
      send_action(make_req(ACT_RESERVE, fid_pool[2 + i % 4], rand_offset(), LEN_MAX, '0));
    end
    send_action(make_req(ACT_RESERVE, rand64(), rand_offset(), rand_length(), '0));
  endtask

  task automatic test_lookup_and_clear();
    send_action(make_req(ACT_FIND, FID_ONES, OFF_MAX, LEN_MAX, '0));
    send_action(make_req(ACT_FIND, '0, OFF_W'(120), LEN_W'(31), '0));
    send_action(make_req(ACT_FIND, '0, '0, '0, '0));
    send_action(make_req(ACT_CLR_OFF, '0, OFF_W'(50), '0, '0));
    send_action(make_req(ACT_CLR_FID, FID_ONES, '0, '0, '0));
    send_action(make_req(ACT_DELETE, '0, '0, '0, SEL_W'(1)));
    send_action(make_req(ACT_UNUSED_HI, FID_ONES, OFF_MAX, LEN_MAX, '1));
    send_action(make_req(ACT_CLR_ALL, '0, '0, '0, '0));
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      send_action(random_action(40));
    end
  endtask

  task automatic test_random_fill(input int count);
    for (int n = 0; n < count; n++) begin
      send_action(random_action(65));
    end
  endtask

  function automatic void report_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
    $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    error_count++;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %0h", $time, rsp);
        error_count++;
      end else begin
        next_expected = awaited_rsp.pop_front();
        if (rsp.status !== next_expected.status)
          report_mismatch("status", 64'(next_expected.status), 64'(rsp.status));
        if (rsp.found_slot !== next_expected.found_slot)
          report_mismatch("found_slot", 64'(next_expected.found_slot), 64'(rsp.found_slot));
        if (rsp.removed_count !== next_expected.removed_count)
          report_mismatch("removed_count", 64'(next_expected.removed_count),
                          64'(rsp.removed_count));
        if (rsp.total_bytes !== next_expected.total_bytes)
          report_mismatch("total_bytes", 64'(next_expected.total_bytes),
                          64'(rsp.total_bytes));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL range_tagged_block_directory");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    idle_cycles <= 0;
    idle_on = 1'b1;
    error_count = 0;
    actions_sent = 0;
    find_hits = 0;
    full_rejects = 0;
    entries_removed = 0;
    dir_total = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_fid[i] = '0;
      dir_start[i] = '0;
      dir_len[i] = '0;
    end
    fid_pool[0] = '0;
    fid_pool[1] = FID_ONES;
    for (int i = 2; i < 6; i++) fid_pool[i] = rand64();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_fill_to_full();
    test_lookup_and_clear();
    test_random_traffic(620);
    idle_on = 1'b0;
    test_random_fill(300);
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    $display("ran %0d actions: %0d find hits, %0d full-table rejects, %0d entries removed",
             actions_sent, find_hits, full_rejects, entries_removed);
    if (error_count == 0) begin
      $display("PASS range_tagged_block_directory");
    end else begin
      $display("FAIL range_tagged_block_directory");
    end
    $finish;
  end

endmodule
